@@ src/pfga_pkg.sv @@
// Shared types and constants for the particle flow grid accumulator.
// Holds the register indexes, the bin record, divider request and response, and the sequencer states.
// No dependencies.
package pfga_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_BINS_X     = 3'd0;
    localparam logic [2:0] REG_BINS_Z     = 3'd1;
    localparam logic [2:0] REG_INV_BW_X   = 3'd2;
    localparam logic [2:0] REG_INV_BW_Z   = 3'd3;
    localparam logic [2:0] REG_BW_X       = 3'd4;
    localparam logic [2:0] REG_BW_Z       = 3'd5;
    localparam logic [2:0] REG_SAMPLES    = 3'd6;
    localparam logic [2:0] REG_INV_2BOLTZ = 3'd7;

    // Divider operand widths
    localparam int DIVW = 64;
    localparam int DSRW = 48;

    // One bin of accumulated sums
    typedef struct packed {
        logic [31:0]        count;
        logic [63:0]        kinetic;
        logic [47:0]        mass;
        logic signed [63:0] mom_x;
        logic signed [63:0] mom_z;
    } bin_t;

    typedef struct packed {
        logic            start;
        logic [DIVW-1:0] dividend;
        logic [DSRW-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic            busy;
        logic            done;
        logic [DIVW-1:0] quot;
        logic [DSRW-1:0] rem;
    } div_rsp_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_MUL,
        S_GX_GO,
        S_GZ_GO,
        S_RD,
        S_ADDR,
        S_LOAD,
        S_CEN,
        S_KIN_GO,
        S_TMUL,
        S_TSUM,
        S_MC_GO,
        S_MM_GO,
        S_FU_GO,
        S_FV_GO,
        S_DONE,
        S_DIV
    } state_t;

endpackage

@@ src/pfga_div.sv @@
// Shared restoring divider: one quotient bit per cycle.
// Depends on pfga_pkg for the request and response structs.
module pfga_div (
    input  logic              clk,
    input  logic              rst_n,
    input  pfga_pkg::div_req_t req,
    output pfga_pkg::div_rsp_t rsp
);

    localparam int CW = $clog2(pfga_pkg::DIVW + 1);

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [CW-1:0]               cnt_reg, cnt_next;
    logic [pfga_pkg::DIVW-1:0]   quot_reg, quot_next;
    logic [pfga_pkg::DSRW-1:0]   rem_reg, rem_next;
    logic [pfga_pkg::DSRW-1:0]   dsr_reg, dsr_next;
    logic [pfga_pkg::DSRW:0]     trial;

    // One restoring step, or load a new request
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        trial     = {rem_reg, quot_reg[pfga_pkg::DIVW-1]};
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quot_next = req.dividend;
            rem_next  = '0;
            dsr_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next  = pfga_pkg::DSRW'(trial - {1'b0, dsr_reg});
                quot_next = {quot_reg[pfga_pkg::DIVW-2:0], 1'b1};
            end
            else
            begin
                rem_next  = trial[pfga_pkg::DSRW-1:0];
                quot_next = {quot_reg[pfga_pkg::DIVW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(pfga_pkg::DIVW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;
    assign rsp.rem  = rem_reg;

endmodule

@@ src/pfga_mem.sv @@
// Bin store: one write port, one read port, registered read data.
// Depends on pfga_pkg for the bin record.
module pfga_mem #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  pfga_pkg::bin_t    wdata,
    input  logic              re,
    input  logic [AW-1:0]     raddr,
    output pfga_pkg::bin_t    rdata
);

    pfga_pkg::bin_t mem [DEPTH];

    // Write and read the array
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ src/particle_flow_grid_accumulator_unit.sv @@
// Particle flow grid accumulator: bins particle samples on an x-z grid.
// Accumulate word: two wrap reductions on the shared divider, then the bin read-modify-write.
// Read word: two wrap reductions and the clearing write of its bin, then five readout divisions.
// One word is in work at a time; a finished result waits in the output register.
// After reset a clearing pass zeroes all MAX_BINS_X*MAX_BINS_Z bins, one per cycle,
// before the first word is taken. Depends on pfga_pkg, pfga_div, pfga_mem.
module particle_flow_grid_accumulator_unit #(
    parameter int MAX_BINS_X = 64,
    parameter int MAX_BINS_Z = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // pos_x, pos_z, vel_x, vel_y, vel_z, mass, read_bin_x, read_bin_z, 4 zero bits
    input  logic [151:0] s_tdata,
    // action, in_group
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // center_x, center_z, mean_count, temperature, mean_mass, flow_u, flow_v
    output logic [175:0] m_tdata,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_addr,
    input  logic [23:0]  cfg_wdata
);

    localparam int DEPTH = MAX_BINS_X * MAX_BINS_Z;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int XW    = (MAX_BINS_X > 1) ? $clog2(MAX_BINS_X) : 1;
    localparam int ZW    = (MAX_BINS_Z > 1) ? $clog2(MAX_BINS_Z) : 1;
    localparam int NXW   = $clog2(MAX_BINS_X + 1);
    localparam int NZW   = $clog2(MAX_BINS_Z + 1);
    localparam logic [23:0] M24 = 24'hFFFFFF;

    // Configuration registers
    logic [6:0]  bins_x_reg, bins_z_reg;
    logic [23:0] inv_bw_x_reg, inv_bw_z_reg, bw_x_reg, bw_z_reg, itb_reg;
    logic [15:0] spo_reg;

    // Sequencer
    pfga_pkg::state_t state_reg, state_next, ret_reg, ret_next;
    logic [AW-1:0]    clr_cnt_reg;

    // Word in work
    logic               act_reg;
    logic signed [23:0] pos_x_reg, pos_z_reg, vx_reg, vy_reg, vz_reg;
    logic [15:0]        mass_reg;
    logic [5:0]         rbx_reg, rbz_reg;

    // Accumulate datapath
    logic signed [47:0] prod_x_reg, prod_z_reg;
    logic [47:0]        sqx_reg, sqy_reg, sqz_reg, v2_reg;
    logic [63:0]        ke_reg;
    logic signed [40:0] mom_x_reg, mom_z_reg;
    logic [XW-1:0]      gx_reg;
    logic [ZW-1:0]      gz_reg;

    // Readout datapath
    pfga_pkg::bin_t bin_reg;
    logic [47:0]    t_hi_reg, t_lo_reg;
    logic [23:0]    temp_reg, mc_reg, cx_reg, cz_reg, fu_reg;
    logic [31:0]    mm_reg;

    // Output register
    logic           out_valid_reg;
    logic [175:0]   out_data_reg;

    // Shared units
    pfga_pkg::div_req_t div_req;
    pfga_pkg::div_rsp_t div_rsp;
    logic               mem_we, mem_re;
    logic [AW-1:0]      mem_waddr, mem_raddr, bin_addr;
    pfga_pkg::bin_t     mem_wdata, mem_rdata, bin_upd;

    logic [NXW-1:0]     nx;
    logic [NZW-1:0]     nz;
    logic [15:0]        spo;
    logic signed [15:0] qx, qz;
    logic [63:0]        dvd_x, dvd_z, mag_x, mag_z;
    logic [XW-1:0]      gx_fix;
    logic [ZW-1:0]      gz_fix;
    logic               out_load;
    logic [64:0]        kin_sum;
    logic [48:0]        mass_add;
    logic signed [64:0] mx_sum, mz_sum;
    logic [33:0]        cx_prod, cz_prod;
    logic [48:0]        t_sum;

    function automatic logic [23:0] flow_sat(input logic [63:0] q, input logic neg);
        logic [63:0] qs;
        if (neg)
        begin
            qs = (q > 64'h800000) ? 64'h800000 : q;
            return 24'(64'd0 - qs);
        end
        qs = (q > 64'h7FFFFF) ? 64'h7FFFFF : q;
        return qs[23:0];
    endfunction

    pfga_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    pfga_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Effective grid sizes and wrap operands
    always_comb
    begin
        if (bins_x_reg == 7'd0)
            nx = NXW'(1);
        else if (32'(bins_x_reg) > MAX_BINS_X)
            nx = NXW'(MAX_BINS_X);
        else
            nx = NXW'(bins_x_reg);
        if (bins_z_reg == 7'd0)
            nz = NZW'(1);
        else if (32'(bins_z_reg) > MAX_BINS_Z)
            nz = NZW'(MAX_BINS_Z);
        else
            nz = NZW'(bins_z_reg);
        spo = (spo_reg == 16'd0) ? 16'd1 : spo_reg;
        qx  = prod_x_reg[47:32];
        qz  = prod_z_reg[47:32];
        dvd_x = act_reg ? 64'(rbx_reg) : 64'(qx[15] ? ~qx : qx);
        dvd_z = act_reg ? 64'(rbz_reg) : 64'(qz[15] ? ~qz : qz);
        gx_fix = (!act_reg && qx[15]) ? XW'(48'(nx) - 48'd1 - div_rsp.rem)
                                      : XW'(div_rsp.rem);
        gz_fix = (!act_reg && qz[15]) ? ZW'(48'(nz) - 48'd1 - div_rsp.rem)
                                      : ZW'(div_rsp.rem);
        bin_addr = AW'(32'(gz_reg) * MAX_BINS_X + 32'(gx_reg));
        mag_x = bin_reg.mom_x[63] ? 64'd0 - 64'(bin_reg.mom_x) : 64'(bin_reg.mom_x);
        mag_z = bin_reg.mom_z[63] ? 64'd0 - 64'(bin_reg.mom_z) : 64'(bin_reg.mom_z);
    end

    // Saturating update of the bin just read
    always_comb
    begin
        kin_sum  = {1'b0, mem_rdata.kinetic} + {1'b0, ke_reg};
        mass_add = {1'b0, mem_rdata.mass} + 49'(mass_reg);
        mx_sum   = {mem_rdata.mom_x[63], mem_rdata.mom_x} + 65'(mom_x_reg);
        mz_sum   = {mem_rdata.mom_z[63], mem_rdata.mom_z} + 65'(mom_z_reg);
        bin_upd.count   = (mem_rdata.count == 32'hFFFFFFFF) ? mem_rdata.count
                                                             : mem_rdata.count + 32'd1;
        bin_upd.kinetic = kin_sum[64] ? 64'hFFFFFFFFFFFFFFFF : kin_sum[63:0];
        bin_upd.mass    = mass_add[48] ? 48'hFFFFFFFFFFFF : mass_add[47:0];
        if (mx_sum[64] != mx_sum[63])
            bin_upd.mom_x = mx_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        else
            bin_upd.mom_x = mx_sum[63:0];
        if (mz_sum[64] != mz_sum[63])
            bin_upd.mom_z = mz_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        else
            bin_upd.mom_z = mz_sum[63:0];
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        case (state_reg)
            pfga_pkg::S_CLEAR:
                if (clr_cnt_reg == AW'(DEPTH - 1))
                    state_next = pfga_pkg::S_IDLE;
            pfga_pkg::S_IDLE:
                if (s_tvalid)
                begin
                    if (s_tuser[0])
                        state_next = pfga_pkg::S_GX_GO;
                    else if (s_tuser[1])
                        state_next = pfga_pkg::S_MUL;
                end
            pfga_pkg::S_MUL:
                state_next = pfga_pkg::S_GX_GO;
            pfga_pkg::S_GX_GO:
            begin
                state_next = pfga_pkg::S_DIV;
                ret_next   = pfga_pkg::S_GZ_GO;
            end
            pfga_pkg::S_GZ_GO:
            begin
                state_next = pfga_pkg::S_DIV;
                ret_next   = pfga_pkg::S_RD;
            end
            pfga_pkg::S_RD:
                state_next = pfga_pkg::S_ADDR;
            pfga_pkg::S_ADDR:
                state_next = pfga_pkg::S_LOAD;
            pfga_pkg::S_LOAD:
                state_next = act_reg ? pfga_pkg::S_CEN : pfga_pkg::S_IDLE;
            pfga_pkg::S_CEN:
                state_next = pfga_pkg::S_KIN_GO;
            pfga_pkg::S_KIN_GO:
            begin
                state_next = pfga_pkg::S_DIV;
                ret_next   = pfga_pkg::S_TMUL;
            end
            pfga_pkg::S_TMUL:
                state_next = pfga_pkg::S_TSUM;
            pfga_pkg::S_TSUM:
                state_next = pfga_pkg::S_MC_GO;
            pfga_pkg::S_MC_GO:
            begin
                state_next = pfga_pkg::S_DIV;
                ret_next   = pfga_pkg::S_MM_GO;
            end
            pfga_pkg::S_MM_GO:
            begin
                state_next = pfga_pkg::S_DIV;
                ret_next   = pfga_pkg::S_FU_GO;
            end
            pfga_pkg::S_FU_GO:
            begin
                state_next = pfga_pkg::S_DIV;
                ret_next   = pfga_pkg::S_FV_GO;
            end
            pfga_pkg::S_FV_GO:
            begin
                state_next = pfga_pkg::S_DIV;
                ret_next   = pfga_pkg::S_DONE;
            end
            pfga_pkg::S_DONE:
                if (out_load)
                    state_next = pfga_pkg::S_IDLE;
            pfga_pkg::S_DIV:
                if (div_rsp.done)
                    state_next = ret_reg;
            default:
                state_next = pfga_pkg::S_IDLE;
        endcase
    end

    // Control outputs
    always_comb
    begin
        s_tready         = (state_reg == pfga_pkg::S_IDLE);
        out_load         = (state_reg == pfga_pkg::S_DONE) && (!out_valid_reg || m_tready);
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        mem_we    = 1'b0;
        mem_waddr = bin_addr;
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = bin_addr;
        case (state_reg)
            pfga_pkg::S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
            end
            pfga_pkg::S_GX_GO:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = dvd_x;
                div_req.divisor  = 48'(nx);
            end
            pfga_pkg::S_GZ_GO:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = dvd_z;
                div_req.divisor  = 48'(nz);
            end
            pfga_pkg::S_ADDR:
                mem_re = 1'b1;
            pfga_pkg::S_LOAD:
            begin
                mem_we    = 1'b1;
                mem_wdata = act_reg ? '0 : bin_upd;
            end
            pfga_pkg::S_KIN_GO:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = bin_reg.kinetic;
                div_req.divisor  = 48'(bin_reg.count);
            end
            pfga_pkg::S_MC_GO:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = 64'({bin_reg.count, 8'd0});
                div_req.divisor  = 48'(spo);
            end
            pfga_pkg::S_MM_GO:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = 64'(bin_reg.mass);
                div_req.divisor  = 48'(spo);
            end
            pfga_pkg::S_FU_GO:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = mag_x;
                div_req.divisor  = bin_reg.mass;
            end
            pfga_pkg::S_FV_GO:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = mag_z;
                div_req.divisor  = bin_reg.mass;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pfga_pkg::S_CLEAR;
            ret_reg       <= pfga_pkg::S_IDLE;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            bins_x_reg    <= 7'd64;
            bins_z_reg    <= 7'd64;
            inv_bw_x_reg  <= 24'd65536;
            inv_bw_z_reg  <= 24'd65536;
            bw_x_reg      <= 24'd65536;
            bw_z_reg      <= 24'd65536;
            spo_reg       <= 16'd1;
            itb_reg       <= 24'd15409;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            if (state_reg == pfga_pkg::S_CLEAR)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
            if (cfg_we)
            begin
                case (cfg_addr)
                    pfga_pkg::REG_BINS_X:     bins_x_reg   <= cfg_wdata[6:0];
                    pfga_pkg::REG_BINS_Z:     bins_z_reg   <= cfg_wdata[6:0];
                    pfga_pkg::REG_INV_BW_X:   inv_bw_x_reg <= cfg_wdata;
                    pfga_pkg::REG_INV_BW_Z:   inv_bw_z_reg <= cfg_wdata;
                    pfga_pkg::REG_BW_X:       bw_x_reg     <= cfg_wdata;
                    pfga_pkg::REG_BW_Z:       bw_z_reg     <= cfg_wdata;
                    pfga_pkg::REG_SAMPLES:    spo_reg      <= cfg_wdata[15:0];
                    pfga_pkg::REG_INV_2BOLTZ: itb_reg      <= cfg_wdata;
                    default:                  spo_reg      <= spo_reg;
                endcase
            end
        end
    end

    // Center and temperature helpers
    always_comb
    begin
        cx_prod = 34'({gx_reg, 1'b1}) * 34'(bw_x_reg);
        cz_prod = 34'({gz_reg, 1'b1}) * 34'(bw_z_reg);
        t_sum   = {1'b0, t_hi_reg} + 49'(t_lo_reg[47:24]);
    end

    // Datapath registers, advanced by the sequencer
    always_ff @(posedge clk)
    begin
        case (state_reg)
            pfga_pkg::S_IDLE:
                if (s_tvalid)
                begin
                    act_reg   <= s_tuser[0];
                    pos_x_reg <= s_tdata[23:0];
                    pos_z_reg <= s_tdata[47:24];
                    vx_reg    <= s_tdata[71:48];
                    vy_reg    <= s_tdata[95:72];
                    vz_reg    <= s_tdata[119:96];
                    mass_reg  <= s_tdata[135:120];
                    rbx_reg   <= s_tdata[141:136];
                    rbz_reg   <= s_tdata[147:142];
                end
            pfga_pkg::S_MUL:
            begin
                prod_x_reg <= 48'(pos_x_reg) * $signed({24'd0, inv_bw_x_reg});
                prod_z_reg <= 48'(pos_z_reg) * $signed({24'd0, inv_bw_z_reg});
                sqx_reg    <= 48'(48'(vx_reg) * 48'(vx_reg));
                sqy_reg    <= 48'(48'(vy_reg) * 48'(vy_reg));
                sqz_reg    <= 48'(48'(vz_reg) * 48'(vz_reg));
                mom_x_reg  <= 41'(vx_reg) * $signed({25'd0, mass_reg});
                mom_z_reg  <= 41'(vz_reg) * $signed({25'd0, mass_reg});
            end
            pfga_pkg::S_GX_GO:
                v2_reg <= sqx_reg + sqy_reg + sqz_reg;
            pfga_pkg::S_GZ_GO:
            begin
                gx_reg <= gx_fix;
                ke_reg <= 64'(v2_reg) * 64'(mass_reg);
            end
            pfga_pkg::S_RD:
                gz_reg <= gz_fix;
            pfga_pkg::S_LOAD:
                bin_reg <= mem_rdata;
            pfga_pkg::S_CEN:
            begin
                cx_reg <= (cx_prod[33:1] > 33'(M24)) ? M24 : cx_prod[24:1];
                cz_reg <= (cz_prod[33:1] > 33'(M24)) ? M24 : cz_prod[24:1];
            end
            pfga_pkg::S_TMUL:
            begin
                t_hi_reg <= 48'(div_rsp.quot[63:40]) * 48'(itb_reg);
                t_lo_reg <= 48'(div_rsp.quot[39:16]) * 48'(itb_reg);
            end
            pfga_pkg::S_TSUM:
                if (bin_reg.count == 32'd0)
                    temp_reg <= '0;
                else
                    temp_reg <= (t_sum > 49'(M24)) ? M24 : t_sum[23:0];
            pfga_pkg::S_MM_GO:
                mc_reg <= (div_rsp.quot > 64'(M24)) ? M24 : div_rsp.quot[23:0];
            pfga_pkg::S_FU_GO:
                mm_reg <= (div_rsp.quot > 64'hFFFFFFFF) ? 32'hFFFFFFFF
                                                         : div_rsp.quot[31:0];
            pfga_pkg::S_FV_GO:
                fu_reg <= (bin_reg.mass == 48'd0) ? 24'd0
                          : flow_sat(div_rsp.quot, bin_reg.mom_x[63]);
            default:
                act_reg <= act_reg;
        endcase
        if (out_load)
        begin
            out_data_reg <= {(bin_reg.mass == 48'd0) ? 24'd0
                                 : flow_sat(div_rsp.quot, bin_reg.mom_z[63]),
                             fu_reg, mm_reg, temp_reg, mc_reg, cz_reg, cx_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTHESIS
    // Memory is written only by the clearing pass or the bin write of the load state
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == pfga_pkg::S_CLEAR || state_reg == pfga_pkg::S_LOAD))
        else $error("bin store written outside clear or update");

    // Never start the divider while it is still iterating
    assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider restarted while busy");

    // A finished result must wait while the output register is still held
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pfga_pkg::S_DONE && m_tvalid && !m_tready)
        |=> (state_reg == pfga_pkg::S_DONE))
        else $error("result dropped over a held output word");

    // No word is taken during the clearing pass
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pfga_pkg::S_CLEAR) |-> !s_tready && !m_tvalid)
        else $error("traffic during clearing pass");
`endif

endmodule

@@ tb/tb.sv @@
// Regression bench for particle_flow_grid_accumulator_unit: drives accumulate and read
// words on the input stream and checks every report against a bin-grid model kept here.
// Depends on pfga_pkg and the RTL under src/.
module tb;

    localparam int NX = 64;
    localparam int NZ = 64;
    localparam int NBINS = NX * NZ;
    localparam longint CYCLE_LIMIT = 4000000;
    localparam int DRAIN_CYCLES = 600;
    localparam int HOLD_CYCLES = 2500;
    localparam bit ACT_ACCUM = 1'b0;
    localparam bit ACT_READ = 1'b1;

    // One readout report, packed in m_tdata order (center_x in the low bits)
    typedef struct packed {
        logic [23:0] flow_v;
        logic [23:0] flow_u;
        logic [31:0] mean_mass;
        logic [23:0] temperature;
        logic [23:0] mean_count;
        logic [23:0] center_z;
        logic [23:0] center_x;
    } bin_report_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [151:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [175:0] m_tdata;
    logic         cfg_we;
    logic [2:0]   cfg_addr;
    logic [23:0]  cfg_wdata;

    // Register shadow
    logic [6:0]  sh_bins_x, sh_bins_z;
    logic [23:0] sh_inv_x, sh_inv_z, sh_bw_x, sh_bw_z, sh_inv_2k;
    logic [15:0] sh_spo;

    // Grid shadow
    logic [31:0]   grid_count [NBINS];
    logic [63:0]   grid_kin [NBINS];
    logic [47:0]   grid_mass [NBINS];
    logic [63:0]   grid_momx [NBINS];
    logic [63:0]   grid_momz [NBINS];

    bin_report_t expected_bins[$];
    int     errors;
    longint cycles;
    bit     calm;
    bit     hold_req;
    int     hold_left;

    particle_flow_grid_accumulator_unit uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    always #4 clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("particle_flow_grid_accumulator_unit regression: fail");
            $finish;
        end
    end

    function automatic int eff_bins(logic [6:0] n, int mx);
        if (n == 0)
            return 1;
        if (int'(n) > mx)
            return mx;
        return int'(n);
    endfunction

    // floor(pos * inv / 2^32), wrapped into [0, n)
    function automatic int wrap_bin(logic [23:0] pos, logic [23:0] inv, int n);
        longint p;
        longint q;
        longint r;
        p = longint'($signed(pos)) * longint'({40'b0, inv});
        q = p >>> 32;
        r = q % n;
        if (r < 0)
            r += n;
        return int'(r);
    endfunction

    function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
            return s[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        return s[63:0];
    endfunction

    function automatic logic [23:0] center_of(int i, logic [23:0] w);
        logic [63:0] c;
        c = (64'(2 * i + 1) * 64'(w)) >> 1;
        return (c > 64'hFF_FFFF) ? 24'hFF_FFFF : c[23:0];
    endfunction

    function automatic logic [23:0] flow_of(logic [63:0] mom, logic [47:0] m);
        logic [63:0] mag;
        logic [63:0] q;
        if (m == 0)
            return 24'd0;
        mag = mom[63] ? (64'd0 - mom) : mom;
        q = mag / 64'(m);
        if (mom[63])
        begin
            if (q > 64'h80_0000)
                q = 64'h80_0000;
            q = 64'd0 - q;
            return q[23:0];
        end
        if (q > 64'h7F_FFFF)
            q = 64'h7F_FFFF;
        return q[23:0];
    endfunction

    // Apply one accepted word to the grid shadow; queue a report for a read
    task automatic fold_word(logic act, logic grp, logic [151:0] d);
        int nx, nz, gx, gz, a;
        longint vx, vy, vz, m;
        logic [63:0] v2, ke, spo, c, e, t, mc, mm;
        logic [64:0] ks;
        logic [48:0] ms;
        bin_report_t r;
        nx = eff_bins(sh_bins_x, NX);
        nz = eff_bins(sh_bins_z, NZ);
        spo = (sh_spo == 0) ? 64'd1 : 64'(sh_spo);
        if (act == ACT_ACCUM)
        begin
            if (!grp)
                return;
            vx = longint'($signed(d[71:48]));
            vy = longint'($signed(d[95:72]));
            vz = longint'($signed(d[119:96]));
            m = longint'(d[135:120]);
            gx = wrap_bin(d[23:0], sh_inv_x, nx);
            gz = wrap_bin(d[47:24], sh_inv_z, nz);
            a = gz * NX + gx;
            v2 = 64'(vx * vx + vy * vy + vz * vz);
            ke = v2 * 64'(m);
            if (grid_count[a] != 32'hFFFF_FFFF)
                grid_count[a]++;
            ks = {1'b0, grid_kin[a]} + {1'b0, ke};
            grid_kin[a] = ks[64] ? 64'hFFFF_FFFF_FFFF_FFFF : ks[63:0];
            ms = {1'b0, grid_mass[a]} + 49'(m);
            grid_mass[a] = ms[48] ? 48'hFFFF_FFFF_FFFF : ms[47:0];
            grid_momx[a] = sat_add(grid_momx[a], 64'(m * vx));
            grid_momz[a] = sat_add(grid_momz[a], 64'(m * vz));
            return;
        end
        gx = int'(d[141:136]) % nx;
        gz = int'(d[147:142]) % nz;
        a = gz * NX + gx;
        c = 64'(grid_count[a]);
        t = 0;
        if (c != 0)
        begin
            e = (grid_kin[a] / c) >> 16;
            t = (e >> 24) * 64'(sh_inv_2k) + (((e & 64'hFF_FFFF) * 64'(sh_inv_2k)) >> 24);
            if (t > 64'hFF_FFFF)
                t = 64'hFF_FFFF;
        end
        mc = (c << 8) / spo;
        if (mc > 64'hFF_FFFF)
            mc = 64'hFF_FFFF;
        mm = 64'(grid_mass[a]) / spo;
        if (mm > 64'hFFFF_FFFF)
            mm = 64'hFFFF_FFFF;
        r.center_x = center_of(gx, sh_bw_x);
        r.center_z = center_of(gz, sh_bw_z);
        r.mean_count = mc[23:0];
        r.temperature = t[23:0];
        r.mean_mass = mm[31:0];
        r.flow_u = flow_of(grid_momx[a], grid_mass[a]);
        r.flow_v = flow_of(grid_momz[a], grid_mass[a]);
        expected_bins.push_back(r);
        grid_count[a] = 0;
        grid_kin[a] = 0;
        grid_mass[a] = 0;
        grid_momx[a] = 0;
        grid_momz[a] = 0;
    endtask

    // Send one word; valid stays high on return so the next call can reuse it
    task automatic send_word(logic act, logic grp, logic [23:0] px, logic [23:0] pz,
                             logic [23:0] vx, logic [23:0] vy, logic [23:0] vz,
                             logic [15:0] m, logic [5:0] rbx, logic [5:0] rbz);
        logic [151:0] d;
        d = {4'b0, rbz, rbx, m, vz, vy, vx, pz, px};
        while (!calm && $urandom_range(99) < 13)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        s_tuser <= {grp, act};
        do
            @(posedge clk);
        while (!s_tready);
        fold_word(act, grp, d);
        @(negedge clk);
    endtask

    task automatic random_word(int read_pct);
        logic act;
        act = ($urandom_range(99) < read_pct) ? ACT_READ : ACT_ACCUM;
        send_word(act, $urandom_range(99) < 90, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, $urandom);
    endtask

    // Drop valid and wait for every report plus the block's longest word time
    task automatic settle();
        s_tvalid <= 1'b0;
        while (expected_bins.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [23:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        case (idx)
            pfga_pkg::REG_BINS_X:     sh_bins_x = val[6:0];
            pfga_pkg::REG_BINS_Z:     sh_bins_z = val[6:0];
            pfga_pkg::REG_INV_BW_X:   sh_inv_x = val;
            pfga_pkg::REG_INV_BW_Z:   sh_inv_z = val;
            pfga_pkg::REG_BW_X:       sh_bw_x = val;
            pfga_pkg::REG_BW_Z:       sh_bw_z = val;
            pfga_pkg::REG_SAMPLES:    sh_spo = val[15:0];
            default:                  sh_inv_2k = val;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic write_all(logic [6:0] bx, logic [6:0] bz, logic [23:0] ix, logic [23:0] iz,
                             logic [23:0] wx, logic [23:0] wz, logic [15:0] spo,
                             logic [23:0] k2);
        write_reg(pfga_pkg::REG_BINS_X, bx);
        write_reg(pfga_pkg::REG_BINS_Z, bz);
        write_reg(pfga_pkg::REG_INV_BW_X, ix);
        write_reg(pfga_pkg::REG_INV_BW_Z, iz);
        write_reg(pfga_pkg::REG_BW_X, wx);
        write_reg(pfga_pkg::REG_BW_Z, wz);
        write_reg(pfga_pkg::REG_SAMPLES, spo);
        write_reg(pfga_pkg::REG_INV_2BOLTZ, k2);
    endtask

    // Directed words under reset settings: field extremes, saturation, group filter
    task automatic test_directed_defaults();
        // saturate kinetic sum in bin (0,0) with two extreme particles
        send_word(ACT_ACCUM, 1, 0, 0, 24'h80_0000, 24'h80_0000, 24'h80_0000, 16'hFFFF, 0, 0);
        send_word(ACT_ACCUM, 1, 0, 0, 24'h7F_FFFF, 24'h80_0000, 24'h7F_FFFF, 16'hFFFF, 0, 0);
        send_word(ACT_ACCUM, 0, 0, 0, 24'h12_3456, 24'h1, 24'h2, 16'h0100, 0, 0);
        send_word(ACT_READ, 0, 24'hFF_FFFF, 24'hFF_FFFF, 0, 0, 0, 0, 0, 0);
        // most negative and most positive positions
        send_word(ACT_ACCUM, 1, 24'h80_0000, 24'h80_0000, 24'h7F_FFFF, 0, 24'h80_0000,
                  16'h0001, 0, 0);
        send_word(ACT_ACCUM, 1, 24'h7F_FFFF, 24'h7F_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 1,
                  16'h0000, 0, 0);
        send_word(ACT_ACCUM, 1, 24'h7F_FFFF, 24'h7F_FFFF, 24'h00_0100, 0, 24'hFF_FF00,
                  16'h0280, 6'h3F, 6'h3F);
        send_word(ACT_READ, 1, 0, 0, 0, 0, 0, 0, 6'h3F, 6'h3F);
        send_word(ACT_READ, 1, 0, 0, 0, 0, 0, 0, 0, 0);
        send_word(ACT_READ, 0, 0, 0, 0, 0, 0, 0, 6'h01, 6'h02);
        settle();
    endtask

    // Degenerate settings: zero bin counts, zero inverse width, zero samples, index wrap
    task automatic test_directed_edges();
        write_all(7'd3, 7'd0, 24'd0, 24'hFF_FFFF, 24'hFF_FFFF, 24'd0, 16'd0, 24'hFF_FFFF);
        send_word(ACT_ACCUM, 1, 24'h7F_FFFF, 24'h00_0001, 24'h40_0000, 24'h40_0000,
                  24'hC0_0000, 16'hFFFF, 0, 0);
        send_word(ACT_ACCUM, 1, 24'h80_0000, 24'h80_0000, 24'h00_0003, 0, 24'h00_0005,
                  16'h0001, 0, 0);
        send_word(ACT_READ, 1, 0, 0, 0, 0, 0, 0, 6'h3F, 6'h3F);
        send_word(ACT_READ, 1, 0, 0, 0, 0, 0, 0, 6'h02, 6'h00);
        settle();
        write_all(7'd127, 7'd64, 24'hFF_FFFF, 24'h1, 24'd0, 24'h00_8000, 16'hFFFF, 24'd0);
        send_word(ACT_ACCUM, 1, 24'h00_0100, 24'h7F_FFFF, 24'h7F_FFFF, 24'h7F_FFFF,
                  24'h7F_FFFF, 16'hFFFF, 0, 0);
        send_word(ACT_READ, 1, 0, 0, 0, 0, 0, 0, 6'h3F, 6'h00);
        send_word(ACT_READ, 1, 0, 0, 0, 0, 0, 0, 6'h00, 6'h3F);
        settle();
    endtask

    // Random traffic under one register setting
    task automatic test_random_phase(int phase, int words);
        case (phase % 6)
            0: write_all(7'd4, 7'd4, $urandom, $urandom, $urandom, $urandom,
                         $urandom_range(8, 1), $urandom);
            1: write_all(7'd1, 7'd127, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF,
                         16'hFFFF, 24'hFF_FFFF);
            2: write_all(7'd64, 7'd64, $urandom_range(16, 0), $urandom_range(16, 0),
                         $urandom, $urandom, 16'd1, 24'd0);
            3: write_all($urandom_range(8, 0), $urandom_range(8, 0), $urandom, $urandom,
                         $urandom, $urandom, $urandom, $urandom);
            4: write_all($urandom_range(127, 0), $urandom_range(6, 1), $urandom, $urandom,
                         $urandom, $urandom, $urandom_range(3, 0), 24'd15409);
            default: write_all(7'd2, 7'd3, 24'd65536, 24'd65536, 24'd65536, 24'd65536,
                               16'd1, 24'd15409);
        endcase
        for (int i = 0; i < words; i++)
            random_word(30);
        settle();
    endtask

    // Hold the receiver off while words keep coming so the input backs up
    task automatic test_backpressure();
        write_all(7'd3, 7'd3, $urandom, $urandom, $urandom, $urandom, 16'd2, $urandom);
        hold_req = 1'b1;
        for (int i = 0; i < 40; i++)
            random_word(50);
        settle();
    endtask

    // Receiver side: random stalls, calm stretches, and the long hold-off
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (hold_left > 0)
            hold_left--;
        m_tready <= (hold_left == 0) && (calm || $urandom_range(99) >= 13);
    end

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    // Compare each report with the oldest expectation
    always @(posedge clk)
    begin
        bin_report_t got, want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (expected_bins.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected report, expected none, actual %h", $time, m_tdata);
            end
            else
            begin
                want = expected_bins.pop_front();
                check_field("center_x", want.center_x, got.center_x);
                check_field("center_z", want.center_z, got.center_z);
                check_field("mean_count", want.mean_count, got.mean_count);
                check_field("temperature", want.temperature, got.temperature);
                check_field("mean_mass", want.mean_mass, got.mean_mass);
                check_field("flow_u", want.flow_u, got.flow_u);
                check_field("flow_v", want.flow_v, got.flow_v);
            end
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        errors = 0;
        cycles = 0;
        calm = 1'b0;
        hold_req = 1'b0;
        hold_left = 0;
        sh_bins_x = 7'd64;
        sh_bins_z = 7'd64;
        sh_inv_x = 24'd65536;
        sh_inv_z = 24'd65536;
        sh_bw_x = 24'd65536;
        sh_bw_z = 24'd65536;
        sh_spo = 16'd1;
        sh_inv_2k = 24'd15409;
        for (int i = 0; i < NBINS; i++)
        begin
            grid_count[i] = 0;
            grid_kin[i] = 0;
            grid_mass[i] = 0;
            grid_momx[i] = 0;
            grid_momz[i] = 0;
        end
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_defaults();
        test_directed_edges();
        for (int p = 0; p < 6; p++)
        begin
            calm = (p == 2);
            test_random_phase(p, 232);
        end
        calm = 1'b0;
        test_backpressure();

        if (errors == 0)
            $display("particle_flow_grid_accumulator_unit regression: pass");
        else
            $display("particle_flow_grid_accumulator_unit regression: fail");
        $finish;
    end

endmodule
